// File: rtl/srte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound-RAM transfer engine package
// Shared payload types, command codes and constants of the transfer engine.
// ----------------------------------------------------------------------------
package srte_pkg;

  localparam int MaxResults = 32;
  localparam int BeatW      = $clog2(MaxResults);

  localparam logic [1:0] KIND_SET_ADDR = 2'd0;
  localparam logic [1:0] KIND_PUSH     = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;

  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_DMA    = 2'd2;

  localparam logic [2:0] TYPE_REP2 = 3'd3;
  localparam logic [2:0] TYPE_REP4 = 3'd4;
  localparam logic [2:0] TYPE_REP8 = 3'd5;

  localparam logic [1:0] CFG_TRANSFER_MODE = 2'd0;
  localparam logic [1:0] CFG_TRANSFER_TYPE = 2'd1;
  localparam logic [1:0] CFG_IRQ_ADDRESS   = 2'd2;
  localparam logic [1:0] CFG_IRQ_ENABLE    = 2'd3;

  typedef enum logic [1:0] {
    OP_SET_ADDR = 2'd0,
    OP_PUSH     = 2'd1,
    OP_TICK     = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [17:0] write_index;
    logic [15:0] write_data;
    logic        irq_hit;
    logic        busy_res;
    logic        push_dropped;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  transfer_mode;
    logic [2:0]  transfer_type;
    logic [15:0] irq_address;
    logic        irq_enable;
  } cfg_t;

endpackage

// File: rtl/srte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer engine front end
// Accepts input beats, decodes the item kind into a command and holds it
// until the command queue takes it.
// ----------------------------------------------------------------------------
module srte_front import srte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd_data
);

  logic valid_r, valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  op_t  op_dec;

  always_comb begin
    unique case (in_data.kind)
      KIND_SET_ADDR: op_dec = OP_SET_ADDR;
      KIND_PUSH:     op_dec = OP_PUSH;
      KIND_TICK:     op_dec = OP_TICK;
      default:       op_dec = OP_NOP;
    endcase
  end

  assign in_ready  = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd_data  = cmd_r;

  always_comb begin
    valid_nxt = valid_r && !cmd_ready;
    cmd_nxt   = cmd_r;
    if (in_valid && in_ready) begin
      valid_nxt      = 1'b1;
      cmd_nxt.op     = op_dec;
      cmd_nxt.value  = in_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

// File: rtl/srte_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer engine command queue
// Two-entry queue that decouples the front end from the write back end.
// ----------------------------------------------------------------------------
module srte_cmd_queue import srte_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_wr, do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/srte_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer engine back end
// Executes commands: loads the address, queues halfwords in the FIFO memory
// and drains them on a service tick into sound-RAM write beats.
// ----------------------------------------------------------------------------
module srte_back import srte_pkg::*; #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  logic [15:0] fifo_mem [FIFO_DEPTH];
  logic [15:0] rd_data_r;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [15:0]     cache_r, cache_nxt;
  logic [2:0]      phase_r, phase_nxt;
  logic [18:0]     addr_r, addr_nxt;
  logic            busy_r, busy_nxt;
  logic [BeatW-1:0] beat_r, beat_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic            out_free;
  logic            mem_we, mem_re;
  logic [CW:0]     tail_sum;
  logic [AW-1:0]   tail;
  logic [AW-1:0]   head_inc;
  logic            drain_ok;
  logic            is_last;
  logic [17:0]     wr_idx;

  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    tail_sum = (CW+1)'(head_r) + (CW+1)'(count_r);
    if (tail_sum >= (CW+1)'(FIFO_DEPTH)) begin
      tail_sum = tail_sum - (CW+1)'(FIFO_DEPTH);
    end
    tail     = tail_sum[AW-1:0];
    head_inc = (head_r == AW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
    drain_ok = (cfg.transfer_mode == MODE_MANUAL || cfg.transfer_mode == MODE_DMA)
               && (count_r != '0);
    is_last  = (count_r == CW'(1)) || (beat_r == BeatW'(MaxResults - 1));
    wr_idx   = addr_r[18:1];
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    cache_nxt     = cache_r;
    phase_nxt     = phase_r;
    addr_nxt      = addr_r;
    busy_nxt      = busy_r;
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd_ready     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready     = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.last = 1'b1;
          unique case (cmd_data.op)
            OP_SET_ADDR: begin
              addr_nxt = {cmd_data.value, 3'b000};
            end
            OP_PUSH: begin
              if (count_r == CW'(FIFO_DEPTH)) begin
                out_data_nxt.push_dropped = 1'b1;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_TICK: begin
              if (drain_ok) begin
                busy_nxt      = 1'b1;
                beat_nxt      = '0;
                out_valid_nxt = out_valid_r && !out_ready;
                out_data_nxt  = out_data_r;
                state_nxt     = ST_READ;
              end else begin
                busy_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
          out_data_nxt.busy_res = busy_nxt;
        end
      end
      ST_READ: begin
        mem_re    = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (out_free) begin
          unique case (cfg.transfer_type)
            TYPE_REP2: begin
              if (!phase_r[0]) cache_nxt = rd_data_r;
              phase_nxt = {2'b00, ~phase_r[0]};
            end
            TYPE_REP4: begin
              if (phase_r[1:0] == 2'd0) cache_nxt = rd_data_r;
              phase_nxt = {1'b0, phase_r[1:0] + 2'd1};
            end
            TYPE_REP8: begin
              if (phase_r == 3'd7) cache_nxt = rd_data_r;
              phase_nxt = phase_r + 3'd1;
            end
            default: begin
              cache_nxt = rd_data_r;
            end
          endcase
          out_valid_nxt            = 1'b1;
          out_data_nxt.write_valid = 1'b1;
          out_data_nxt.write_index = wr_idx;
          out_data_nxt.write_data  = cache_nxt;
          out_data_nxt.irq_hit     = cfg.irq_enable && (wr_idx == {cfg.irq_address, 2'b00});
          out_data_nxt.busy_res    = busy_r;
          out_data_nxt.push_dropped = 1'b0;
          out_data_nxt.last        = is_last;
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
          addr_nxt  = addr_r + 19'd2;
          beat_nxt  = beat_r + 1'b1;
          state_nxt = is_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fifo_mem[tail] <= cmd_data.value;
    end
    if (mem_re) begin
      rd_data_r <= fifo_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      cache_r     <= '0;
      phase_r     <= '0;
      addr_r      <= '0;
      busy_r      <= 1'b0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      cache_r     <= cache_nxt;
      phase_r     <= phase_nxt;
      addr_r      <= addr_nxt;
      busy_r      <= busy_nxt;
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

// File: rtl/sound_ram_transfer_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound-RAM transfer engine
// Address load, halfword FIFO and tick-driven drain into sound-RAM writes.
// ----------------------------------------------------------------------------
// An address load, push or idle tick passes the front register, the command queue
// and the back-end output register; a draining tick gives its first write after a
// registered FIFO memory read. Loads, pushes and idle ticks leave the back end free
// for the next command. A draining tick alternates a FIFO read and a write beat per
// halfword, up to 32 halfwords per tick. Reset is synchronous and active low; it
// clears all control state, and FIFO contents are undefined until written.
module sound_ram_transfer_engine import srte_pkg::*; #(
  parameter int FIFO_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic fq_valid, fq_ready;
  cmd_t fq_data;
  logic qb_valid, qb_ready;
  cmd_t qb_data;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TRANSFER_MODE: cfg_nxt.transfer_mode = cfg_data[1:0];
        CFG_TRANSFER_TYPE: cfg_nxt.transfer_type = cfg_data[2:0];
        CFG_IRQ_ADDRESS:   cfg_nxt.irq_address   = cfg_data;
        CFG_IRQ_ENABLE:    cfg_nxt.irq_enable    = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.transfer_mode <= 2'd0;
      cfg_r.transfer_type <= 3'd2;
      cfg_r.irq_address   <= 16'd0;
      cfg_r.irq_enable    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  srte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  srte_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  srte_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
